// File: rtl/core/idalloc_pkg.sv
// shared types, constants and helpers for the identifier allocator
`timescale 1ns / 1ps

package idalloc_pkg;

    localparam int ID_W       = 32;
    localparam int FREE_DEPTH = 256;
    localparam int PTR_W      = $clog2(FREE_DEPTH);
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int RC_W       = ID_W + 1;

    localparam logic [ID_W-1:0]  ID_MAX    = {ID_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FREE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FREE_DEPTH - 1);

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_GET_LOW = 2'd1,
        CMD_RETURN  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OUT_OF_IDS = 2'd1,
        ST_QUEUE_FULL = 2'd2
    } status_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_LAST)
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

// File: rtl/core/idalloc_ram.sv
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps

module idalloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/id_allocator_with_free_queue.sv
// identifier allocator: bump counter plus fifo of returned identifiers
`timescale 1ns / 1ps
// result: registered, in the cycle after the request transaction; a queue pop passes through S_FETCH first
// throughput: 1 transaction per cycle while the result is taken; a pop holds off the next request until S_FETCH ends,
//   as the pop needs one read of the free queue ram to fetch the new queue head
// reset (rst_n low, async): base id, counter, exhausted flag, queue pointers and count cleared;
//   free queue ram contents are not cleared, only occupied entries are ever used

module id_allocator_with_free_queue
    import idalloc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration: base id write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ID_W-1:0]        cfg_data,

    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ID_W-1:0]        s_tdata,   // [31:0] id_value
    input  logic [1:0]             s_tuser,   // [1:0] command

    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [103:0]           m_tdata    // [31:0] id_out, [33:32] status,
                                              // [65:34] next_low_id, [98:66] reserved_count,
                                              // [103:99] zero
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

    // control and architectural state
    state_t           state_reg, state_next;
    logic [ID_W-1:0]  base_reg, base_next;
    logic [ID_W-1:0]  counter_reg, counter_next;
    logic             exh_reg, exh_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // cached copy of the entry at the queue head
    logic [ID_W-1:0]  head_data_reg, head_data_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    status_t          out_status_reg, out_status_next;
    logic [ID_W-1:0]  out_nl_reg, out_nl_next;
    logic [RC_W-1:0]  out_rc_reg, out_rc_next;

    // ram port signals
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [ID_W-1:0]  ram_rdata;

    logic             in_fire;
    logic             cfg_fire;
    cmd_t             cmd;
    logic             q_empty;
    logic             do_pop;
    logic             do_take;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // new request only when idle and the result slot is free or draining now
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign q_empty  = (count_reg == '0);

    // pop: get while exhausted with queue entries, or get_low with queue entries
    assign do_pop  = ((cmd == CMD_GET) && exh_reg && !q_empty)
                  || ((cmd == CMD_GET_LOW) && !q_empty);
    // take from the bump counter
    assign do_take = ((cmd == CMD_GET) || ((cmd == CMD_GET_LOW) && q_empty)) && !exh_reg;

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        counter_next    = counter_reg;
        exh_next        = exh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        head_data_next  = head_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_nl_next     = out_nl_reg;
        out_rc_next     = out_rc_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_re          = 1'b0;
        ram_raddr       = ptr_inc(head_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_id_next     = '0;
                    out_status_next = ST_OK;
                    unique case (cmd)
                        CMD_GET, CMD_GET_LOW:
                        begin
                            if (do_pop)
                            begin
                                out_id_next = head_data_reg;
                                head_next   = ptr_inc(head_reg);
                                count_next  = count_reg - CNT_W'(1);
                                ram_re      = 1'b1;
                            end
                            else if (do_take)
                            begin
                                out_id_next = counter_reg;
                                if (counter_reg == ID_MAX)
                                    exh_next = 1'b1;
                                else
                                    counter_next = counter_reg + ID_W'(1);
                            end
                            else
                            begin
                                out_status_next = ST_OUT_OF_IDS;
                            end
                        end
                        CMD_RETURN:
                        begin
                            priority if (exh_reg && (s_tdata == counter_reg))
                            begin
                                exh_next = 1'b0;
                            end
                            else if (!exh_reg && (s_tdata == counter_reg - ID_W'(1)))
                            begin
                                counter_next = counter_reg - ID_W'(1);
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                out_status_next = ST_QUEUE_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = ptr_inc(tail_reg);
                                count_next = count_reg + CNT_W'(1);
                                if (q_empty)
                                    head_data_next = s_tdata;
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase

                    // reserved count from the updated counter and queue count
                    out_rc_next = {1'b0, counter_next} - {1'b0, base_reg}
                                - RC_W'(count_next)
                                + RC_W'(counter_next == ID_MAX);

                    if (count_next != '0)
                        out_nl_next = head_data_next;
                    else if (exh_next)
                        out_nl_next = '0;
                    else
                        out_nl_next = counter_next;

                    if (do_pop && (cmd != CMD_RETURN) && (cmd != CMD_NOP))
                        state_next = S_FETCH;
                    else
                        out_valid_next = 1'b1;
                end
            end
            S_FETCH:
            begin
                // new head entry arrives from the ram this cycle
                head_data_next = ram_rdata;
                if (!q_empty)
                    out_nl_next = ram_rdata;
                else if (exh_reg)
                    out_nl_next = '0;
                else
                    out_nl_next = counter_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // base id write reloads the counter; the user must write it only while idle, the block does not enforce this
        if (cfg_fire)
        begin
            base_next    = cfg_data;
            counter_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            counter_reg   <= '0;
            exh_reg       <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            counter_reg   <= counter_next;
            exh_reg       <= exh_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        head_data_reg  <= head_data_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_nl_reg     <= out_nl_next;
        out_rc_reg     <= out_rc_next;
    end

    // free queue storage
    idalloc_ram #(
        .WIDTH (ID_W),
        .DEPTH (FREE_DEPTH)
    ) u_free_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_rc_reg, out_nl_reg, out_status_reg, out_id_reg};

    // the result slot is always free while a head fetch is in flight
    a_fetch_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !out_valid_reg)
        else $error("result register busy during head fetch");

    // a head fetch completes in the following cycle, returning to idle with the result presented
    a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> ((state_reg == S_IDLE) && out_valid_reg))
        else $error("head fetch did not complete in one cycle");

    // every accepted request yields a pending result or a head fetch
    a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (out_valid_reg || (state_reg == S_FETCH)))
        else $error("accepted request produced nothing");

    // queue count stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("free queue count overflow");

    // no ram write and read at once (push and pop never share an item)
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("free queue written and read in the same cycle");

endmodule
